@@ sv/fspa_pkg.sv @@
// Shared types and constants of the fixed slot pool allocator.
// No dependencies; imported by the divider and the top level.
package fspa_pkg;

    localparam int ADDR_W    = 48;   // byte addresses
    localparam int SIZE_W    = 21;   // size register
    localparam int CNT_W     = 7;    // count register, free count
    localparam int REQ_W     = 32;   // requested bytes
    localparam int FBC_W     = 32;   // fallback counter
    localparam int STAT_W    = 3;
    localparam int STRIDE_W  = 22;   // slot size rounded up always fits here
    localparam int QUOT_W    = 22;   // quotient bits resolved by the divider
    localparam int DIVD_W    = 48;   // dividend / remainder width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_GRANT      = 3'd0,
        STAT_FALLBACK   = 3'd1,
        STAT_FREED      = 3'd2,
        STAT_NOT_OWNED  = 3'd3,
        STAT_NULL       = 3'd4,
        STAT_MISALIGNED = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REBUILD,
        S_STRIDE_GO,
        S_STRIDE_SET,
        S_MUL,
        S_ALLOC,
        S_CHECK,
        S_DIV_WAIT,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                start;
        logic [DIVD_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DIVD_W-1:0] rem;
    } t_div_rsp;

endpackage

@@ sv/fspa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; holds the free-list link memory.
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fspa_div.sv @@
// Restoring divider, one quotient bit per cycle, QUOT_W quotient bits per start.
// Depends on fspa_pkg; the quotient must fit in QUOT_W bits.
module fspa_div
    import fspa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_dsr;     // divisor aligned to the current quotient bit
    logic [QUOT_W-1:0] r_quot;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic              ge;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_dsr  <= DIVD_W'(i_req.divisor) << (QUOT_W - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quot <= {r_quot[QUOT_W-2:0], ge};
            r_dsr  <= r_dsr >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ sv/fixed_slot_pool_allocator.sv @@
// Fixed-size slot pool allocator: LIFO free list with links in a RAM.
// Depends on fspa_pkg, fspa_ram (link memory) and fspa_div (offset divider).
//
// One request is in work at a time. An allocate goes from the accepting state through
// the multiply, allocate and done states; a free of the null address or of an address
// outside the pool goes through multiply, check and done. A free of an address inside
// the pool waits after the check until the byte offset is turned into a slot index by
// a 22-step restoring divider, then pushes the slot and goes to done. The done state
// waits while the output register holds a result that is not yet taken. The result
// sits in an output register, so the next request is taken while it waits. After reset
// and after each count register write the link RAM is rebuilt in a pass over all
// MAX_SLOTS entries; after reset and after each size register write the stride is
// recomputed in the stride go and stride set states by a multiply with the constant
// reciprocal of ALIGN_BYTES. No request is accepted during either; configuration beats are always taken.
module fixed_slot_pool_allocator
    import fspa_pkg::*;
#(
    parameter int MAX_SLOTS   = 64,
    parameter int ALIGN_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,  // req_size[31:0], addr[79:32]
    input  logic                 s_axis_tuser,  // func
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [87:0]          m_axis_tdata,  // slot_addr[47:0], free_slots[54:48],
                                                // fallback_total[86:55], pad[87]
    output logic [STAT_W-1:0]    m_axis_tuser,  // status
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int HEAD_W = $clog2(MAX_SLOTS + 1);
    localparam int MA_W   = (HEAD_W > CNT_W) ? HEAD_W : CNT_W;
    localparam int PROD_W = MA_W + STRIDE_W;
    localparam int SUM_W  = ADDR_W + 1;

    // rounding to ALIGN_BYTES: exact floor division by a reciprocal multiply
    localparam int RCP_SH = STRIDE_W + $clog2(ALIGN_BYTES);
    localparam int RCP_W  = STRIDE_W + 1;
    localparam int RCP_PW = STRIDE_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

    t_state r_state, n_state;

    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [CNT_W-1:0]    r_count;
    logic [STRIDE_W-1:0] r_stride;
    logic [RCP_PW-1:0]   r_rcp_prod;
    logic                r_rebuild_req, r_stride_req;
    logic [HEAD_W-1:0]   r_fill;
    logic [HEAD_W-1:0]   r_head;
    logic [CNT_W-1:0]    r_free_total;
    logic [FBC_W-1:0]    r_fbc;

    logic                r_func;
    logic [REQ_W-1:0]    r_req;
    logic [ADDR_W-1:0]   r_addr;
    logic [PROD_W-1:0]   r_prod;
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [CNT_W-1:0]    r_out_free;
    logic [FBC_W-1:0]    r_out_fbc;

    // FSM outputs
    logic                in_rdy;
    logic                ram_re, ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [HEAD_W-1:0]   ram_wdata;
    logic [HEAD_W-1:0]   ram_rdata;
    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic                out_load;

    logic                in_beat, cfg_beat;
    logic                start_rebuild, start_stride, fill_last;
    logic [CNT_W-1:0]    cnt_nz, eff_cnt;
    logic [SIZE_W-1:0]   size_nz;
    logic [STRIDE_W-1:0] size_rnd, rcp_quot;
    logic [MA_W-1:0]     mul_a;
    logic [SUM_W-1:0]    pool_end;
    logic                is_null, in_pool, grant, push, misaligned;

    assign cfg_beat = i_cfg_valid & o_cfg_ready;
    assign in_beat  = s_axis_tvalid & s_axis_tready;

    assign cnt_nz  = (r_count == '0) ? CNT_W'(1) : r_count;
    assign eff_cnt = (MA_W'(cnt_nz) > MA_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cnt_nz;
    assign size_nz = (r_size == '0) ? SIZE_W'(1) : r_size;

    assign size_rnd = STRIDE_W'(size_nz) + STRIDE_W'(ALIGN_BYTES - 1);
    assign rcp_quot = STRIDE_W'(r_rcp_prod >> RCP_SH);

    assign start_rebuild = (r_state == S_IDLE) && r_rebuild_req;
    assign start_stride  = (r_state == S_IDLE) && !r_rebuild_req && r_stride_req;
    assign fill_last     = (r_fill == HEAD_W'(MAX_SLOTS - 1));

    // allocate uses head * stride, free uses count * stride: one multiplier
    assign mul_a = (r_func == FUNC_FREE) ? MA_W'(eff_cnt) : MA_W'(r_head);

    assign pool_end = {1'b0, r_base} + SUM_W'(r_prod);
    assign is_null  = (r_addr == '0);
    assign in_pool  = (r_addr >= r_base) && ({1'b0, r_addr} < pool_end);
    assign grant    = (r_req <= REQ_W'(r_stride)) && (r_free_total != '0)
                      && (r_head < HEAD_W'(MAX_SLOTS));
    assign misaligned = (div_rsp.rem != '0);
    // a full list means the slot cannot be outstanding
    assign push     = !misaligned && (r_free_total < eff_cnt)
                      && (div_rsp.quot < QUOT_W'(MAX_SLOTS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_rebuild_req)      n_state = S_REBUILD;
                else if (r_stride_req)  n_state = S_STRIDE_GO;
                else if (s_axis_tvalid) n_state = S_MUL;
            end
            S_REBUILD:     if (fill_last) n_state = S_IDLE;
            S_STRIDE_GO:   n_state = S_STRIDE_SET;
            S_STRIDE_SET:  n_state = S_IDLE;
            S_MUL:         n_state = (r_func == FUNC_FREE) ? S_CHECK : S_ALLOC;
            S_ALLOC:       n_state = S_DONE;
            S_CHECK:       n_state = (is_null || !in_pool) ? S_DONE : S_DIV_WAIT;
            S_DIV_WAIT:    if (div_rsp.done) n_state = S_FREE;
            S_FREE:        n_state = S_DONE;
            S_DONE:        if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_rdy           = 1'b0;
        ram_re           = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = r_fill[IDX_W-1:0];
        ram_wdata        = r_fill + 1'b1;
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(r_addr - r_base);
        div_req.divisor  = r_stride;
        out_load         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_rdy = !r_rebuild_req && !r_stride_req;
                ram_re = in_rdy;   // prefetch link of the head
            end
            S_REBUILD: ram_we = 1'b1;
            S_CHECK: div_req.start = !is_null && in_pool;
            S_FREE: begin
                ram_we    = push;
                ram_waddr = div_rsp.quot[IDX_W-1:0];
                ram_wdata = r_head;
            end
            S_DONE: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_base        <= '0;
            r_size        <= SIZE_W'(40000);
            r_count       <= CNT_W'(64);
            r_rebuild_req <= 1'b1;
            r_stride_req  <= 1'b1;
            r_fill        <= '0;
            r_head        <= '0;
            r_free_total  <= '0;
            r_fbc         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_beat && i_cfg_index == CFG_BASE)  r_base  <= i_cfg_data[ADDR_W-1:0];
            if (cfg_beat && i_cfg_index == CFG_SIZE)  r_size  <= i_cfg_data[SIZE_W-1:0];
            if (cfg_beat && i_cfg_index == CFG_COUNT) r_count <= i_cfg_data[CNT_W-1:0];

            r_rebuild_req <= (cfg_beat && i_cfg_index == CFG_COUNT)
                             || (r_rebuild_req && !start_rebuild);
            r_stride_req  <= (cfg_beat && i_cfg_index == CFG_SIZE)
                             || (r_stride_req && !start_stride);

            if (start_rebuild) begin
                r_fill <= '0;
            end else if (r_state == S_REBUILD) begin
                r_fill <= r_fill + 1'b1;
                if (fill_last) begin
                    r_head       <= '0;
                    r_free_total <= eff_cnt;
                end
            end

            if (r_state == S_ALLOC) begin
                if (grant) begin
                    r_head       <= ram_rdata;
                    r_free_total <= r_free_total - 1'b1;
                end else begin
                    r_fbc <= r_fbc + 1'b1;
                end
            end

            if (r_state == S_FREE && push) begin
                r_head       <= div_rsp.quot[HEAD_W-1:0];
                r_free_total <= r_free_total + 1'b1;
            end

            if (out_load)           r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_func <= s_axis_tuser;
            r_req  <= s_axis_tdata[31:0];
            r_addr <= s_axis_tdata[79:32];
        end
        if (r_state == S_STRIDE_GO) begin
            r_rcp_prod <= RCP_PW'(size_rnd) * RCP_PW'(RCP);
        end
        if (r_state == S_STRIDE_SET) begin
            r_stride <= rcp_quot * STRIDE_W'(ALIGN_BYTES);
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(r_stride);
        end
        case (r_state)
            S_ALLOC: begin
                r_res_status <= grant ? STAT_GRANT : STAT_FALLBACK;
                r_res_addr   <= grant ? (r_base + ADDR_W'(r_prod)) : '0;
            end
            S_CHECK: begin
                r_res_status <= is_null ? STAT_NULL : STAT_NOT_OWNED;
                r_res_addr   <= '0;
            end
            S_FREE: begin
                r_res_addr <= '0;
                if (misaligned)  r_res_status <= STAT_MISALIGNED;
                else if (push)   r_res_status <= STAT_FREED;
                else             r_res_status <= STAT_NOT_OWNED;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_free   <= r_free_total;
            r_out_fbc    <= r_fbc;
        end
    end

    fspa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    fspa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = in_rdy;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {1'b0, r_out_fbc, r_out_free, r_out_addr};

    // free count never passes the pool size once the list is rebuilt
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_rebuild_req && r_state != S_REBUILD) |-> (r_free_total <= eff_cnt))
        else $error("free count exceeds slot count");

    // only a grant carries a nonzero slot address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STAT_GRANT) |-> (m_axis_tdata[47:0] == '0))
        else $error("slot address on a non-grant result");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider result with nobody waiting");

    // an accepted request goes straight to the multiply step
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_MUL))
        else $error("accepted request lost");

endmodule
